// File: hw/rtl/assert_macros.svh
// Assertion macros for the RTL files that carry checks; only the allocator top includes them.
// No dependencies; included by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Expression must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst_n, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (expr)) \
        else $error(msg);

// Same-cycle implication.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hw/rtl/fsfl_pkg.sv
// Package for the fixed-slot free-list allocator: widths, codes, command/status structs.
// No dependencies; used by scoped names from every module of the block but fsfl_ram.
package fsfl_pkg;

    localparam int SLOTS        = 256;
    localparam int HEADER_BYTES = 40;
    localparam int LINK_BYTES   = 16;

    localparam int SLOT_W     = $clog2(SLOTS);
    localparam int CNT_W      = SLOT_W + 1;
    localparam int POOL_W     = 32;
    localparam int OBJ_W      = 16;
    localparam int BLOCK_W    = OBJ_W + 1;
    localparam int REM_W      = BLOCK_W + SLOT_W;
    localparam int PROD_W     = BLOCK_W + SLOT_W;
    localparam int OFF_W      = 32;
    localparam int STEP_W     = $clog2(SLOT_W);
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = POOL_W;

    localparam logic [POOL_W-1:0] POOL_RESET = POOL_W'(4136);
    localparam logic [OBJ_W-1:0]  OBJ_RESET  = '0;

    // Output tdata layout: slot, offset, free count, capacity, zero pad.
    localparam int OUT_FIELDS_W = SLOT_W + OFF_W + CNT_W + CNT_W;
    localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;
    localparam int OUT_PAD_W    = OUT_TDATA_W - OUT_FIELDS_W;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_POOL_BYTES   = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_OBJECT_BYTES = 1'b1;

    // Request opcodes
    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_RANGE = 2'd2,
        ST_FULL  = 2'd3
    } t_status;

    typedef struct packed {
        logic cap_start;   // latch divisor, check saturation
        logic cap_step;    // one quotient bit
        logic fill_write;  // load one ring entry with its own index
        logic take_req;    // capture incoming request
        logic exec;        // update pointers, issue ring read/write
        logic capture;     // take ring read data, multiply
        logic push;        // load the output register
    } t_dp_cmd;

    typedef struct packed {
        logic cap_last;    // current divide step is the last one
        logic fill_done;   // ring holds all free slots
        logic out_room;    // output register can take a result
    } t_dp_stat;

endpackage

// File: hw/rtl/fixed_slot_free_list_allocator.sv
// Fixed-slot pool allocator with a FIFO free list of up to 256 slots. After reset, and after
// every register write, the block sizes the pool as
// (pool_bytes - 40) / (object_bytes + 16), capped at 256 and zero when the region is smaller
// than the 40-byte header, then loads the free ring with slots 0 .. capacity-1. During that
// setup (one setup step, eight shift-subtract divide steps, one ring write per slot, one
// closing check) s_axis_tready stays low; register writes are taken at any time and
// restart it. A request is then one of: allocate (tuser 0), which takes the slot at the
// ring head and returns its index and payload byte offset 40 + slot*(object_bytes+16) + 16,
// or status empty; or free (tuser 1), which appends tdata's slot at the ring tail,
// returning status out-of-range or full when it is rejected.
// Each request passes through the exec, read and push states before the next tready: the
// ring RAM has a registered read and the offset multiply is registered before the output
// stage. One request is handled at a time; the result sits in an output register, so the
// block returns to ready while that result waits for m_axis_tready. Double frees of an
// in-range slot are not detected unless the list is already full.
// Depends on fsfl_pkg, fsfl_ctrl, fsfl_datapath, fsfl_ram and assert_macros.svh.
`include "assert_macros.svh"

module fixed_slot_free_list_allocator (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // configuration writes
    input  logic                                i_cfg_we,
    input  logic [fsfl_pkg::CFG_IDX_W-1:0]      i_cfg_addr,
    input  logic [fsfl_pkg::CFG_DATA_W-1:0]     i_cfg_wdata,
    // requests
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [fsfl_pkg::SLOT_W-1:0]         s_axis_tdata,   // [7:0] slot_to_free
    input  logic                                s_axis_tuser,   // [0] op
    // results
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    output logic [fsfl_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,   // [7:0] slot_index,
                                                                // [39:8] byte_offset,
                                                                // [48:40] free_count,
                                                                // [57:49] pool_slots,
                                                                // [63:58] zero
    output logic [1:0]                          m_axis_tuser    // [1:0] status
);

    fsfl_pkg::t_dp_cmd  dp_cmd;
    fsfl_pkg::t_dp_stat dp_stat;

    logic [fsfl_pkg::SLOT_W-1:0] out_slot;
    logic [fsfl_pkg::OFF_W-1:0]  out_offset;
    fsfl_pkg::t_status           out_status;
    logic [fsfl_pkg::CNT_W-1:0]  out_free;
    logic [fsfl_pkg::CNT_W-1:0]  out_cap;

    // assertion terms
    logic                        empty_res;
    logic                        empty_res_clean;
    logic                        full_res;

    fsfl_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_stat     (dp_stat),
        .o_cmd      (dp_cmd)
    );

    fsfl_datapath u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_addr      (i_cfg_addr),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_req_op        (s_axis_tuser),
        .i_req_slot      (s_axis_tdata),
        .i_cmd           (dp_cmd),
        .o_stat          (dp_stat),
        .i_out_ready     (m_axis_tready),
        .o_out_valid     (m_axis_tvalid),
        .o_slot_index    (out_slot),
        .o_byte_offset   (out_offset),
        .o_status        (out_status),
        .o_free_count    (out_free),
        .o_pool_slots    (out_cap)
    );

    assign m_axis_tdata = {{fsfl_pkg::OUT_PAD_W{1'b0}}, out_cap, out_free, out_offset, out_slot};
    assign m_axis_tuser = out_status;

    // ---------------- assertions ----------------
    assign empty_res       = m_axis_tvalid && (out_status == fsfl_pkg::ST_EMPTY);
    assign empty_res_clean = (out_slot == '0) && (out_offset == '0) && (out_free == '0);
    assign full_res        = m_axis_tvalid && (out_status == fsfl_pkg::ST_FULL);

    // a register write always takes the block out of ready while the pool is rebuilt
    `ASSERT_NEXT(a_cfg_drops_ready, i_clk, i_rst_n, i_cfg_we, !s_axis_tready, "ready after write")

    // free count reported never exceeds the pool capacity
    `ASSERT_IMPLIES(a_free_le_cap, i_clk, i_rst_n, m_axis_tvalid, out_free <= out_cap, "free > cap")

    // an empty allocate reports nothing handed out and no free slots
    `ASSERT_IMPLIES(a_empty_result, i_clk, i_rst_n, empty_res, empty_res_clean, "bad empty result")

    // a rejected free on a full list reports a full count
    `ASSERT_IMPLIES(a_full_result, i_clk, i_rst_n, full_res, out_free == out_cap, "full, count short")

endmodule

// File: hw/rtl/fsfl_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module fsfl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: hw/rtl/fsfl_datapath.sv
// Allocator datapath: config registers, capacity divider, free ring, pointers, output register.
// Depends on fsfl_pkg and fsfl_ram.
module fsfl_datapath (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [fsfl_pkg::CFG_IDX_W-1:0]   i_cfg_addr,
    input  logic [fsfl_pkg::CFG_DATA_W-1:0]  i_cfg_wdata,
    input  logic                             i_req_op,
    input  logic [fsfl_pkg::SLOT_W-1:0]      i_req_slot,
    input  fsfl_pkg::t_dp_cmd                i_cmd,
    output fsfl_pkg::t_dp_stat               o_stat,
    input  logic                             i_out_ready,
    output logic                             o_out_valid,
    output logic [fsfl_pkg::SLOT_W-1:0]      o_slot_index,
    output logic [fsfl_pkg::OFF_W-1:0]       o_byte_offset,
    output fsfl_pkg::t_status                o_status,
    output logic [fsfl_pkg::CNT_W-1:0]       o_free_count,
    output logic [fsfl_pkg::CNT_W-1:0]       o_pool_slots
);

    // config
    logic [fsfl_pkg::POOL_W-1:0]  r_pool;
    logic [fsfl_pkg::OBJ_W-1:0]   r_obj;

    // divider
    logic [fsfl_pkg::BLOCK_W-1:0] r_block;
    logic [fsfl_pkg::REM_W-1:0]   r_rem;
    logic [fsfl_pkg::REM_W-1:0]   r_dsr;
    logic [fsfl_pkg::SLOT_W-1:0]  r_quo;
    logic [fsfl_pkg::STEP_W-1:0]  r_step;
    logic                         r_force;
    logic [fsfl_pkg::CNT_W-1:0]   r_force_cap;

    // free list state
    logic [fsfl_pkg::CNT_W-1:0]   r_cap;
    logic [fsfl_pkg::CNT_W-1:0]   r_free;
    logic [fsfl_pkg::SLOT_W-1:0]  r_head;
    logic [fsfl_pkg::SLOT_W-1:0]  r_tail;
    logic [fsfl_pkg::CNT_W-1:0]   r_fill;

    // request in flight
    logic                         r_op;
    logic [fsfl_pkg::SLOT_W-1:0]  r_req;
    fsfl_pkg::t_status            r_status;
    logic                         r_alloc_ok;
    logic [fsfl_pkg::SLOT_W-1:0]  r_slot;
    logic [fsfl_pkg::PROD_W-1:0]  r_prod;

    // output register
    logic                         r_out_valid;
    logic [fsfl_pkg::SLOT_W-1:0]  r_o_slot;
    logic [fsfl_pkg::OFF_W-1:0]   r_o_off;
    fsfl_pkg::t_status            r_o_status;
    logic [fsfl_pkg::CNT_W-1:0]   r_o_free;
    logic [fsfl_pkg::CNT_W-1:0]   r_o_cap;

    logic [fsfl_pkg::BLOCK_W-1:0] block_w;
    logic [fsfl_pkg::POOL_W-1:0]  diff;
    logic [fsfl_pkg::POOL_W-1:0]  sat_lim;
    logic                         fits;
    logic [fsfl_pkg::SLOT_W-1:0]  quo_next;
    logic [fsfl_pkg::CNT_W-1:0]   cap_next;

    logic                         alloc_ok_c;
    logic                         free_ok_c;
    fsfl_pkg::t_status            status_c;

    logic                         ram_we;
    logic [fsfl_pkg::SLOT_W-1:0]  ram_waddr;
    logic [fsfl_pkg::SLOT_W-1:0]  ram_wdata;
    logic [fsfl_pkg::SLOT_W-1:0]  ram_rdata;

    // ---------------- config ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pool <= fsfl_pkg::POOL_RESET;
            r_obj  <= fsfl_pkg::OBJ_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                fsfl_pkg::CFG_POOL_BYTES:   r_pool <= i_cfg_wdata;
                fsfl_pkg::CFG_OBJECT_BYTES: r_obj  <= i_cfg_wdata[fsfl_pkg::OBJ_W-1:0];
                default: ;
            endcase
        end
    end

    // ---------------- capacity divider ----------------
    assign block_w  = {1'b0, r_obj} + fsfl_pkg::BLOCK_W'(fsfl_pkg::LINK_BYTES);
    assign diff     = r_pool - fsfl_pkg::POOL_W'(fsfl_pkg::HEADER_BYTES);
    assign sat_lim  = fsfl_pkg::POOL_W'({block_w, {fsfl_pkg::SLOT_W{1'b0}}});
    assign fits     = (r_rem >= r_dsr);
    assign quo_next = {r_quo[fsfl_pkg::SLOT_W-2:0], fits};
    assign cap_next = r_force ? r_force_cap : {1'b0, quo_next};

    always_ff @(posedge i_clk) begin
        if (i_cmd.cap_start) begin
            r_block <= block_w;
            r_dsr   <= {1'b0, block_w, {(fsfl_pkg::SLOT_W-1){1'b0}}};
            r_quo   <= '0;
            r_step  <= fsfl_pkg::STEP_W'(fsfl_pkg::SLOT_W - 1);
            r_rem   <= diff[fsfl_pkg::REM_W-1:0];
            if (r_pool < fsfl_pkg::POOL_W'(fsfl_pkg::HEADER_BYTES)) begin
                r_force     <= 1'b1;
                r_force_cap <= '0;
            end else if (block_w == '0 || diff >= sat_lim) begin
                r_force     <= 1'b1;
                r_force_cap <= fsfl_pkg::CNT_W'(fsfl_pkg::SLOTS);
            end else begin
                r_force     <= 1'b0;
                r_force_cap <= '0;
            end
        end else if (i_cmd.cap_step) begin
            if (fits) begin
                r_rem <= r_rem - r_dsr;
            end
            r_dsr  <= r_dsr >> 1;
            r_quo  <= quo_next;
            r_step <= r_step - 1'b1;
        end
    end

    // ---------------- request decode ----------------
    always_comb begin
        alloc_ok_c = (r_op == fsfl_pkg::OP_ALLOC) && (r_free != '0);
        free_ok_c  = 1'b0;
        status_c   = fsfl_pkg::ST_OK;
        if (r_op == fsfl_pkg::OP_ALLOC) begin
            if (r_free == '0) begin
                status_c = fsfl_pkg::ST_EMPTY;
            end
        end else if ({1'b0, r_req} >= r_cap) begin
            status_c = fsfl_pkg::ST_RANGE;
        end else if (r_free >= r_cap) begin
            status_c = fsfl_pkg::ST_FULL;
        end else begin
            free_ok_c = 1'b1;
        end
    end

    // ---------------- list state ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap  <= '0;
            r_free <= '0;
            r_head <= '0;
            r_tail <= '0;
            r_fill <= '0;
        end else if (i_cmd.cap_step && r_step == '0) begin
            r_cap  <= cap_next;
            r_free <= cap_next;
            r_head <= '0;
            r_tail <= cap_next[fsfl_pkg::SLOT_W-1:0];
            r_fill <= '0;
        end else if (i_cmd.fill_write) begin
            r_fill <= r_fill + 1'b1;
        end else if (i_cmd.exec) begin
            if (alloc_ok_c) begin
                r_head <= r_head + 1'b1;
                r_free <= r_free - 1'b1;
            end else if (free_ok_c) begin
                r_tail <= r_tail + 1'b1;
                r_free <= r_free + 1'b1;
            end
        end
    end

    // ---------------- request payload ----------------
    always_ff @(posedge i_clk) begin
        if (i_cmd.take_req) begin
            r_op  <= i_req_op;
            r_req <= i_req_slot;
        end
        if (i_cmd.exec) begin
            r_status   <= status_c;
            r_alloc_ok <= alloc_ok_c;
        end
        if (i_cmd.capture) begin
            if (r_alloc_ok) begin
                r_slot <= ram_rdata;
                r_prod <= fsfl_pkg::PROD_W'(ram_rdata) * fsfl_pkg::PROD_W'(r_block);
            end else begin
                r_slot <= (r_op == fsfl_pkg::OP_FREE) ? r_req : '0;
                r_prod <= '0;
            end
        end
    end

    // ---------------- free ring ----------------
    assign ram_we    = i_cmd.fill_write || (i_cmd.exec && free_ok_c);
    assign ram_waddr = i_cmd.fill_write ? r_fill[fsfl_pkg::SLOT_W-1:0] : r_tail;
    assign ram_wdata = i_cmd.fill_write ? r_fill[fsfl_pkg::SLOT_W-1:0] : r_req;

    fsfl_ram #(
        .WIDTH (fsfl_pkg::SLOT_W),
        .DEPTH (fsfl_pkg::SLOTS)
    ) u_ring (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (i_cmd.exec && alloc_ok_c),
        .i_raddr (r_head),
        .o_rdata (ram_rdata)
    );

    // ---------------- output register ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.push) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.push) begin
            r_o_slot   <= r_slot;
            r_o_off    <= r_alloc_ok
                        ? fsfl_pkg::OFF_W'(r_prod)
                          + fsfl_pkg::OFF_W'(fsfl_pkg::HEADER_BYTES + fsfl_pkg::LINK_BYTES)
                        : '0;
            r_o_status <= r_status;
            r_o_free   <= r_free;
            r_o_cap    <= r_cap;
        end
    end

    assign o_stat.cap_last  = (r_step == '0);
    assign o_stat.fill_done = (r_fill == r_cap);
    assign o_stat.out_room  = !r_out_valid || i_out_ready;

    assign o_out_valid     = r_out_valid;
    assign o_slot_index    = r_o_slot;
    assign o_byte_offset   = r_o_off;
    assign o_status        = r_o_status;
    assign o_free_count    = r_o_free;
    assign o_pool_slots    = r_o_cap;

endmodule

// File: hw/rtl/fsfl_ctrl.sv
// Allocator controller: sequences pool setup (divide, ring fill) and each request.
// Depends on fsfl_pkg.
module fsfl_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  fsfl_pkg::t_dp_stat i_stat,
    output fsfl_pkg::t_dp_cmd  o_cmd
);

    typedef enum logic [2:0] {
        S_START,
        S_CALC,
        S_FILL,
        S_IDLE,
        S_EXEC,
        S_READ,
        S_PUSH
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_in_ready;
    logic   accept;

    assign accept = i_in_valid && r_in_ready;

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_START: n_state = S_CALC;
            S_CALC:  if (i_stat.cap_last) n_state = S_FILL;
            S_FILL:  if (i_stat.fill_done) n_state = S_IDLE;
            S_IDLE:  if (accept) n_state = S_EXEC;
            S_EXEC:  n_state = S_READ;
            S_READ:  n_state = S_PUSH;
            S_PUSH:  if (i_stat.out_room) n_state = S_IDLE;
            default: n_state = S_START;
        endcase
        // any register write rebuilds the pool
        if (i_cfg_we) begin
            n_state = S_START;
        end
    end

    always_comb begin
        o_cmd            = '0;
        o_cmd.cap_start  = (r_state == S_START);
        o_cmd.cap_step   = (r_state == S_CALC);
        o_cmd.fill_write = (r_state == S_FILL) && !i_stat.fill_done;
        o_cmd.take_req   = accept;
        o_cmd.exec       = (r_state == S_EXEC);
        o_cmd.capture    = (r_state == S_READ);
        o_cmd.push       = (r_state == S_PUSH) && i_stat.out_room;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_START;
            r_in_ready <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_in_ready <= (n_state == S_IDLE);
        end
    end

    assign o_in_ready = r_in_ready;

endmodule

// File: verif/fsfl_checker.sv
// Scoreboard for fixed_slot_free_list_allocator: tracks config writes, predicts each result.
// Depends on fsfl_pkg; instantiated by tb_top next to the DUT.
module fsfl_checker
    import fsfl_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cfg_we,
    input  logic [CFG_IDX_W-1:0]     i_cfg_addr,
    input  logic [CFG_DATA_W-1:0]    i_cfg_wdata,
    input  logic                     s_axis_tvalid,
    input  logic                     s_axis_tready,
    input  logic [SLOT_W-1:0]        s_axis_tdata,   // [7:0] slot_to_free
    input  logic                     s_axis_tuser,   // [0] op
    input  logic                     m_axis_tvalid,
    input  logic                     m_axis_tready,
    input  logic [OUT_TDATA_W-1:0]   m_axis_tdata,   // [7:0] slot, [39:8] offset,
                                                     // [48:40] free, [57:49] capacity
    input  logic [1:0]               m_axis_tuser,   // [1:0] status
    output int                       o_mismatches,
    output int                       o_outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic [SLOT_W-1:0] slot;
        logic [OFF_W-1:0]  offset;
        t_status           status;
        logic [CNT_W-1:0]  free_count;
        logic [CNT_W-1:0]  capacity;
    } t_slot_grant;

    // shadow of the block state
    logic [SLOT_W-1:0] ring [SLOTS];
    logic [SLOT_W-1:0] head_idx;
    logic [SLOT_W-1:0] tail_idx;
    logic [CNT_W-1:0]  n_free;
    logic [CNT_W-1:0]  n_slots;
    logic [POOL_W-1:0] pool_bytes;
    logic [OBJ_W-1:0]  obj_bytes;

    t_slot_grant grants_due[$];
    int          errs = 0;

    // Size the pool and refill the ring with 0 .. capacity-1.
    function automatic void reload_pool();
        longint unsigned region;
        longint unsigned stride;
        longint unsigned quo;
        region = pool_bytes;
        stride = obj_bytes;
        stride = stride + LINK_BYTES;
        if (region < HEADER_BYTES)
            quo = 0;
        else
            quo = (region - HEADER_BYTES) / stride;
        if (quo > SLOTS)
            quo = SLOTS;
        n_slots = CNT_W'(quo);
        for (int i = 0; i < SLOTS; i++)
            ring[i] = (i < quo) ? SLOT_W'(i) : '0;
        head_idx = '0;
        tail_idx = SLOT_W'(quo);
        n_free   = n_slots;
    endfunction

    function automatic t_slot_grant serve_request(logic op, logic [SLOT_W-1:0] slot);
        t_slot_grant     r;
        longint unsigned off;
        r.slot   = '0;
        r.offset = '0;
        r.status = ST_OK;
        if (op == OP_ALLOC) begin
            if (n_free == 0) begin
                r.status = ST_EMPTY;
            end else begin
                r.slot   = ring[head_idx];
                head_idx = head_idx + 1'b1;
                n_free   = n_free - 1'b1;
                off      = obj_bytes;
                off      = HEADER_BYTES + r.slot * (off + LINK_BYTES) + LINK_BYTES;
                r.offset = off[OFF_W-1:0];
            end
        end else begin
            r.slot = slot;
            if (slot >= n_slots) begin
                r.status = ST_RANGE;
            end else if (n_free >= n_slots) begin
                r.status = ST_FULL;
            end else begin
                ring[tail_idx] = slot;
                tail_idx       = tail_idx + 1'b1;
                n_free         = n_free + 1'b1;
            end
        end
        r.free_count = n_free;
        r.capacity   = n_slots;
        return r;
    endfunction

    function automatic void check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
        if (act_v !== exp_v) begin
            $error("%s: expected %0d, got %0d", name, exp_v, act_v);
            errs++;
        end
    endfunction

    always @(posedge i_clk) begin
        t_slot_grant want;
        if (!i_rst_n) begin
            pool_bytes = POOL_RESET;
            obj_bytes  = OBJ_RESET;
            reload_pool();
            grants_due.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_addr)
                    CFG_POOL_BYTES: begin
                        pool_bytes = i_cfg_wdata;
                        reload_pool();
                    end
                    CFG_OBJECT_BYTES: begin
                        obj_bytes = i_cfg_wdata[OBJ_W-1:0];
                        reload_pool();
                    end
                    default: ;
                endcase
            end
            // result side first: it always belongs to an older request
            if (m_axis_tvalid && m_axis_tready) begin
                if (grants_due.size() == 0) begin
                    $error("result with no request outstanding");
                    errs++;
                end else begin
                    want = grants_due.pop_front();
                    check_field("slot_index", 32'(want.slot), 32'(m_axis_tdata[7:0]));
                    check_field("byte_offset", want.offset, m_axis_tdata[39:8]);
                    check_field("status", 32'(want.status), 32'(m_axis_tuser));
                    check_field("free_count", 32'(want.free_count), 32'(m_axis_tdata[48:40]));
                    check_field("pool_slots", 32'(want.capacity), 32'(m_axis_tdata[57:49]));
                end
            end
            if (s_axis_tvalid && s_axis_tready)
                grants_due.push_back(serve_request(s_axis_tuser, s_axis_tdata));
        end
        o_mismatches  <= errs;
        o_outstanding <= grants_due.size();
    end

endmodule

// File: verif/tb_top.sv
// Top of the allocator testbench: clock, reset, config writes, request and result traffic.
// Depends on fsfl_pkg, fixed_slot_free_list_allocator and fsfl_checker.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import fsfl_pkg::*;

    localparam int RAND_REQUESTS = 1500;
    // Longest legal quiet stretch is a ring reload plus stalls; keep plenty of margin.
    localparam int QUIET_LIMIT   = 5000;

    logic                    i_clk = 1'b0;
    logic                    i_rst_n = 1'b0;
    logic                    i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]    i_cfg_addr = CFG_POOL_BYTES;
    logic [CFG_DATA_W-1:0]   i_cfg_wdata = '0;
    logic                    s_axis_tvalid = 1'b0;
    logic                    s_axis_tready;
    logic [SLOT_W-1:0]       s_axis_tdata = '0;     // [7:0] slot_to_free
    logic                    s_axis_tuser = OP_ALLOC; // [0] op
    logic                    m_axis_tvalid;
    logic                    m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0]  m_axis_tdata;          // [7:0] slot, [39:8] offset,
                                                    // [48:40] free, [57:49] capacity
    logic [1:0]              m_axis_tuser;          // [1:0] status

    int mismatch_count;
    int results_outstanding;

    // Random gaps on both sides; cleared in some phases to get back-to-back stretches.
    bit gaps_on = 1'b1;
    int sent = 0;
    int quiet_cycles = 0;
    int stall_left = 0;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    fixed_slot_free_list_allocator DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    fsfl_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .o_mismatches  (mismatch_count),
        .o_outstanding (results_outstanding)
    );

    // Result side: after each accepted result, hold tready low for a random stall.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            stall_left = 0;
        end else if (m_axis_tvalid && m_axis_tready) begin
            stall_left = gaps_on ? $urandom_range(0, 4) : 0;
        end else if (stall_left > 0) begin
            stall_left--;
        end
        m_axis_tready <= i_rst_n && (stall_left == 0);
    end

    // Watchdog: any accept on either side resets the quiet count.
    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // One request. Valid is only dropped when a gap is drawn, so a back-to-back
    // request never sees valid lowered and raised in the same step.
    task automatic send_req(input logic op, input logic [SLOT_W-1:0] slot);
        int gap;
        gap = gaps_on ? $urandom_range(0, 4) : 0;
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= slot;
        do @(posedge i_clk); while (!s_axis_tready);
        sent++;
    endtask

    // Stop sending and wait until every outstanding result has come back.
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (results_outstanding != 0);
        // output register is the last stage, so once the count is zero the pipe is empty
        repeat (4) @(posedge i_clk);
    endtask

    // Write both registers back to back while the block is idle.
    task automatic load_config(input logic [POOL_W-1:0] pool, input logic [OBJ_W-1:0] obj,
                               input bit pool_first);
        drain();
        i_cfg_we    <= 1'b1;
        i_cfg_addr  <= pool_first ? CFG_POOL_BYTES : CFG_OBJECT_BYTES;
        i_cfg_wdata <= pool_first ? pool : CFG_DATA_W'(obj);
        @(posedge i_clk);
        i_cfg_addr  <= pool_first ? CFG_OBJECT_BYTES : CFG_POOL_BYTES;
        i_cfg_wdata <= pool_first ? CFG_DATA_W'(obj) : pool;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    initial begin
        int               kind;
        int               n_items;
        int               alloc_pct;
        int               hi_slot;
        int unsigned      target;
        logic [POOL_W-1:0] pool;
        logic [OBJ_W-1:0]  obj;

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // --- directed part ---
        // Reset config: 4096 / 16 = 256 slots, ring full.
        send_req(OP_ALLOC, 8'hFF);   // alloc field ignored
        send_req(OP_ALLOC, 8'h00);
        send_req(OP_ALLOC, 8'hA5);
        send_req(OP_FREE, 8'hFF);    // top slot, never allocated: double free goes through
        send_req(OP_FREE, 8'h00);
        send_req(OP_FREE, 8'h80);    // list full again
        send_req(OP_FREE, 8'h01);    // free with a full list is rejected

        // region smaller than the header -> no slots
        load_config(32'd39, 16'hFFFF, 1'b1);
        send_req(OP_ALLOC, 8'h00);   // empty
        send_req(OP_FREE, 8'h00);    // out of range

        // exactly the header -> still zero slots
        load_config(32'd40, 16'h0000, 1'b0);
        send_req(OP_ALLOC, 8'h00);

        // one slot
        load_config(32'd56, 16'h0000, 1'b1);
        send_req(OP_ALLOC, 8'h00);
        send_req(OP_ALLOC, 8'h00);   // empty
        send_req(OP_FREE, 8'h01);    // out of range
        send_req(OP_FREE, 8'h00);
        send_req(OP_FREE, 8'h00);    // full

        // both registers at max: capacity saturates
        load_config(32'hFFFF_FFFF, 16'hFFFF, 1'b0);
        send_req(OP_ALLOC, 8'h3C);
        send_req(OP_ALLOC, 8'hC3);
        send_req(OP_FREE, 8'hFF);
        send_req(OP_FREE, 8'h00);
        send_req(OP_FREE, 8'h01);    // full

        // --- random phases, each under a fresh config ---
        sent = 0;
        while (sent < RAND_REQUESTS) begin
            kind = $urandom_range(0, 9);
            obj  = ($urandom_range(0, 3) == 0) ? 16'($urandom_range(0, 65535))
                                               : 16'($urandom_range(0, 64));
            alloc_pct = $urandom_range(25, 75);
            n_items   = $urandom_range(30, 120);
            case (kind)
                0: begin            // too small for any slot
                    pool    = $urandom_range(0, HEADER_BYTES - 1);
                    hi_slot = 255;
                end
                1: begin            // anything goes
                    pool    = $urandom;
                    obj     = 16'($urandom_range(0, 65535));
                    hi_slot = 255;
                end
                2: begin            // saturated at 256, drive it toward empty
                    obj       = 16'($urandom_range(0, 15));
                    pool      = HEADER_BYTES + SLOTS * (obj + LINK_BYTES)
                              + $urandom_range(0, 1 << 20);
                    hi_slot   = 255;
                    alloc_pct = $urandom_range(60, 90);
                    n_items   = $urandom_range(200, 400);
                end
                default: begin      // small pool so empty and full come often
                    target  = $urandom_range(1, 24);
                    pool    = HEADER_BYTES + target * (obj + LINK_BYTES)
                            + $urandom_range(0, obj + LINK_BYTES - 1);
                    hi_slot = target - 1;
                end
            endcase
            load_config(pool, obj, 1'($urandom_range(0, 1)));
            gaps_on = ($urandom_range(0, 3) != 0);

            repeat (n_items) begin
                if ($urandom_range(0, 99) < alloc_pct)
                    send_req(OP_ALLOC, SLOT_W'($urandom_range(0, 255)));
                else if ($urandom_range(0, 99) < 85)
                    send_req(OP_FREE, SLOT_W'($urandom_range(0, hi_slot)));
                else
                    send_req(OP_FREE, SLOT_W'($urandom_range(0, 255)));
                // now and then let the pipe run dry mid-phase
                if ($urandom_range(0, 59) == 0)
                    drain();
            end
        end

        drain();
        repeat (20) @(posedge i_clk);
        if (mismatch_count == 0 && results_outstanding == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

// File: sim.f
+incdir+hw/rtl
hw/rtl/fsfl_pkg.sv
hw/rtl/fsfl_ram.sv
hw/rtl/fsfl_datapath.sv
hw/rtl/fsfl_ctrl.sv
hw/rtl/fixed_slot_free_list_allocator.sv
verif/fsfl_checker.sv
verif/tb_top.sv
